// ----- sv/bounded_stack_calculator_assert.svh -----
// Assertion macros shared by the stack calculator.
`ifndef BOUNDED_STACK_CALCULATOR_ASSERT_SVH
`define BOUNDED_STACK_CALCULATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BSC_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define BSC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// ----- sv/bsc_pkg.sv -----
// Shared types, constants and helpers of the stack calculator.
package bsc_pkg;

    localparam int STACK_DEPTH_DEFAULT = 1024;
    localparam int DIV_W = 31;
    localparam logic [29:0] MAG_LIMIT_RESET = 30'd1000000000;
    localparam logic [10:0] DEPTH_LIMIT_RESET = 11'd1000;

    typedef enum logic [0:0] {
        REG_MAG_LIMIT = 1'b0,
        REG_DEPTH_LIMIT = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_START = 4'd0,
        OP_NUM = 4'd1,
        OP_POP = 4'd2,
        OP_INV = 4'd3,
        OP_DUP = 4'd4,
        OP_SWP = 4'd5,
        OP_ADD = 4'd6,
        OP_SUB = 4'd7,
        OP_MUL = 4'd8,
        OP_DIV = 4'd9,
        OP_MOD = 4'd10,
        OP_FINISH = 4'd11
    } op_t;

    typedef enum logic [2:0] {
        CL_START,
        CL_FINISH,
        CL_PUSH,
        CL_UNARY,
        CL_BINARY,
        CL_BAD
    } cls_t;

    typedef struct packed {
        op_t op;
        cls_t cls;
        logic signed [30:0] operand;
    } item_t;

    function automatic logic too_big(input logic signed [61:0] v, input logic [29:0] m);
        logic signed [61:0] lim;
        lim = $signed({32'd0, m});
        return (v > lim) || (v < -lim);
    endfunction

endpackage

// ----- sv/bounded_stack_calculator.sv -----
// Top level of the bounded stack calculator.
//
// Instruction words enter on in_valid/in_stall with mode and operand; one
// result word per instruction leaves on out_valid/out_stall with error,
// top_value, depth and final_ok. A word is taken at a clock edge with valid
// high and stall low.
// A two-entry input queue feeds a sequencer that keeps the stack top in a
// register and the deeper entries in a memory with one read and one write port.
// START, FINISH and ignored words go from the idle state straight to the
// response state; NUM, INV and DUP pass through execute and depth check,
// POP may also refill the top, SWP also fetches, ADD, SUB and MUL fetch and
// check the result, and DIV or MOD also wait for the bit-serial divider.
// Items are executed one at a time; results leave through an output
// register, so a stalled receiver holds at most one finished result while
// the next item executes, then the sequencer waits and the queue fills.
// Reset empties the stack, clears the error flag and loads the limit
// registers with their defaults. The user must write limits via cfg_write,
// cfg_index and cfg_data while no item is in flight; this is not enforced.
module bounded_stack_calculator
    import bsc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         mode,
    input  logic signed [30:0] operand,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               error,
    output logic signed [30:0] top_value,
    output logic [10:0]        depth,
    output logic               final_ok,
    input  logic               cfg_write,
    input  logic [0:0]         cfg_index,
    input  logic [29:0]        cfg_data
);

`include "bounded_stack_calculator_assert.svh"

    logic        q_valid;
    item_t       q_item;
    logic        q_pop;
    logic [29:0] mag_limit_reg;
    logic [10:0] depth_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_limit_reg <= MAG_LIMIT_RESET;
            depth_limit_reg <= DEPTH_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MAG_LIMIT:   mag_limit_reg <= cfg_data;
                REG_DEPTH_LIMIT: depth_limit_reg <= cfg_data[10:0];
                default:         mag_limit_reg <= mag_limit_reg;
            endcase
        end
    end

    bsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .operand  (operand),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    bsc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .mag_limit   (mag_limit_reg),
        .depth_limit (depth_limit_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .error       (error),
        .top_value   (top_value),
        .depth       (depth),
        .final_ok    (final_ok)
    );

    `BSC_ASSERT_IMPLY(a_ok_clean, clk, rst_n, out_valid && final_ok, !error && depth == 11'd1)
    `BSC_ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid && depth == 11'd0, top_value == '0)
    `BSC_ASSERT_NEXT(a_pop_only_nonempty, clk, rst_n, q_pop, !$past(!q_valid))

endmodule

// ----- sv/bsc_front.sv -----
// Front end: accepts words, classifies them and queues them for execution.
module bsc_front
    import bsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         mode,
    input  logic signed [30:0] operand,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_pop
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    item_t       item_in;

    always_comb
    begin
        item_in.op = op_t'(mode);
        item_in.operand = operand;
        case (mode) inside
            OP_START:                        item_in.cls = CL_START;
            OP_FINISH:                       item_in.cls = CL_FINISH;
            OP_NUM:                          item_in.cls = CL_PUSH;
            [OP_POP:OP_DUP]:                 item_in.cls = CL_UNARY;
            [OP_SWP:OP_MOD]:                 item_in.cls = CL_BINARY;
            default:                         item_in.cls = CL_BAD;
        endcase
    end

    assign in_stall = (count_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (count_reg != 2'd0);
    assign q_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ----- sv/bsc_div.sv -----
// Iterative restoring divider on unsigned magnitudes, one bit a cycle.
module bsc_div
    import bsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_W-1:0]   dividend,
    input  logic [DIV_W-1:0]   divisor,
    output logic               done,
    output logic [DIV_W-1:0]   quotient,
    output logic [DIV_W-1:0]   remainder
);

    localparam int CW = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_diff;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = CW'(DIV_W - 1);
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- sv/bsc_back.sv -----
// Back end: executes queued words on the stack and registers each result.
module bsc_back
    import bsc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    input  logic [29:0]        mag_limit,
    input  logic [10:0]        depth_limit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               error,
    output logic signed [30:0] top_value,
    output logic [10:0]        depth,
    output logic               final_ok
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_FETCH, S_DIVW, S_CHECK, S_REFILL, S_DCHK, S_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic [DW-1:0]         depth_reg, depth_next;
    logic                  err_reg, err_next;
    logic                  ok_reg, ok_next;
    logic signed [30:0]    top_reg, top_next;
    item_t                 item_reg, item_next;
    logic signed [61:0]    res_reg, res_next;
    logic                  ov_reg, ov_next;
    logic                  oerr_reg, oerr_next;
    logic signed [30:0]    otop_reg, otop_next;
    logic [10:0]           odepth_reg, odepth_next;
    logic                  ook_reg, ook_next;

    logic signed [30:0]    mem [STACK_DEPTH];
    logic signed [30:0]    rd_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic signed [30:0]    mem_wdata;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    logic                  div_start;
    logic                  div_done;
    logic [DIV_W-1:0]      div_a, div_b, div_q, div_r;
    logic [DIV_W-1:0]      div_sel;
    logic                  div_neg;

    logic [DW-1:0]         dm1, dm2, dm3;
    logic                  full;

    function automatic logic [DIV_W-1:0] mag(input logic signed [30:0] v);
        logic signed [30:0] n;
        n = -v;
        return v[30] ? n : v;
    endfunction

    assign dm1 = depth_reg - 1'b1;
    assign dm2 = depth_reg - 2'd2;
    assign dm3 = depth_reg - 2'd3;
    assign full = 32'(depth_reg) >= STACK_DEPTH;
    assign div_a = mag(rd_reg);
    assign div_b = mag(top_reg);
    assign div_sel = (item_reg.op == OP_DIV) ? div_q : div_r;
    assign div_neg = (item_reg.op == OP_DIV) ? (rd_reg[30] != top_reg[30]) : rd_reg[30];

    bsc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next = state_reg;
        depth_next = depth_reg;
        err_next = err_reg;
        ok_next = ok_reg;
        top_next = top_reg;
        item_next = item_reg;
        res_next = res_reg;
        ov_next = ov_reg && out_stall;
        oerr_next = oerr_reg;
        otop_next = otop_reg;
        odepth_next = odepth_reg;
        ook_next = ook_reg;
        q_pop = 1'b0;
        mem_we = 1'b0;
        mem_waddr = dm1[AW-1:0];
        mem_wdata = top_reg;
        rd_en = 1'b0;
        rd_addr = dm2[AW-1:0];
        div_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    item_next = q_item;
                    ok_next = 1'b0;
                    state_next = S_RESP;
                    case (q_item.cls)
                        CL_START:
                        begin
                            err_next = too_big(62'(q_item.operand), mag_limit);
                            depth_next = err_next ? '0 : DW'(1);
                            top_next = q_item.operand;
                        end
                        CL_FINISH:
                        begin
                            ok_next = !err_reg && (depth_reg == DW'(1));
                        end
                        default:
                        begin
                            if (!err_reg)
                            begin
                                state_next = S_EXEC;
                            end
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                state_next = S_DCHK;
                case (item_reg.cls)
                    CL_PUSH:
                    begin
                        if (too_big(62'(item_reg.operand), mag_limit) || full)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            mem_we = (depth_reg != '0);
                            top_next = item_reg.operand;
                            depth_next = depth_reg + 1'b1;
                        end
                    end
                    CL_UNARY:
                    begin
                        if (depth_reg == '0)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            case (item_reg.op)
                                OP_POP:
                                begin
                                    depth_next = dm1;
                                    if (32'(depth_reg) >= 2)
                                    begin
                                        rd_en = 1'b1;
                                        state_next = S_REFILL;
                                    end
                                end
                                OP_INV:
                                begin
                                    top_next = -top_reg;
                                end
                                default:
                                begin
                                    if (too_big(62'(top_reg), mag_limit) || full)
                                    begin
                                        err_next = 1'b1;
                                    end
                                    else
                                    begin
                                        mem_we = 1'b1;
                                        depth_next = depth_reg + 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    CL_BINARY:
                    begin
                        if (32'(depth_reg) < 2)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            rd_en = 1'b1;
                            state_next = S_FETCH;
                        end
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
            S_FETCH:
            begin
                state_next = S_CHECK;
                case (item_reg.op)
                    OP_SWP:
                    begin
                        mem_we = 1'b1;
                        mem_waddr = dm2[AW-1:0];
                        top_next = rd_reg;
                        state_next = S_DCHK;
                    end
                    OP_ADD:
                    begin
                        res_next = 62'(rd_reg) + 62'(top_reg);
                    end
                    OP_SUB:
                    begin
                        res_next = 62'(rd_reg) - 62'(top_reg);
                    end
                    OP_MUL:
                    begin
                        res_next = rd_reg * top_reg;
                    end
                    default:
                    begin
                        if (top_reg == '0)
                        begin
                            err_next = 1'b1;
                            state_next = S_DCHK;
                        end
                        else
                        begin
                            div_start = 1'b1;
                            state_next = S_DIVW;
                        end
                    end
                endcase
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    res_next = div_neg ? -$signed({31'd0, div_sel}) : $signed({31'd0, div_sel});
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_DCHK;
                if (too_big(res_reg, mag_limit))
                begin
                    err_next = 1'b1;
                    depth_next = dm2;
                    if (32'(depth_reg) >= 3)
                    begin
                        rd_en = 1'b1;
                        rd_addr = dm3[AW-1:0];
                        state_next = S_REFILL;
                    end
                end
                else
                begin
                    top_next = res_reg[30:0];
                    depth_next = dm1;
                end
            end
            S_REFILL:
            begin
                top_next = rd_reg;
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                if ((depth_reg == '0) || (32'(depth_reg) >= 32'(depth_limit)))
                begin
                    err_next = 1'b1;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    oerr_next = err_reg;
                    otop_next = (depth_reg != '0) ? top_reg : '0;
                    odepth_next = 11'(depth_reg);
                    ook_next = ok_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            err_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            err_reg <= err_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
        top_reg <= top_next;
        item_reg <= item_next;
        res_reg <= res_next;
        oerr_reg <= oerr_next;
        otop_reg <= otop_next;
        odepth_reg <= odepth_next;
        ook_reg <= ook_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign out_valid = ov_reg;
    assign error = oerr_reg;
    assign top_value = otop_reg;
    assign depth = odepth_reg;
    assign final_ok = ook_reg;

endmodule

// ----- bench/tb.sv -----
// Testbench for the bounded stack calculator: directed and random instruction words checked against a predictor.
`timescale 1ns / 100ps

module tb;
    import bsc_pkg::*;

    localparam int LIMIT_CYCLES = 900000;
    localparam int STORE_SIZE = STACK_DEPTH_DEFAULT;
    localparam int OPND_MAX = 1000000000;

    typedef struct {
        logic               error;
        logic signed [30:0] top_value;
        logic [10:0]        depth;
        logic               final_ok;
    } calc_result_t;

    class calc_scoreboard;
        longint       stack_mem[STORE_SIZE];
        int           stack_depth;
        bit           err_flag;
        longint       mag_limit;
        longint       depth_limit;
        calc_result_t expected_q[$];
        int           mismatches;

        function new();
            stack_depth = 0;
            err_flag = 0;
            mag_limit = MAG_LIMIT_RESET;
            depth_limit = DEPTH_LIMIT_RESET;
            mismatches = 0;
        endfunction

        function void set_limit(reg_idx_t idx, logic [29:0] value);
            if (idx == REG_MAG_LIMIT)
                mag_limit = value;
            else
                depth_limit = value[10:0];
        endfunction

        function bit over_limit(longint v);
            return (v > mag_limit) || (v < -mag_limit);
        endfunction

        function void push_value(longint v);
            if (over_limit(v) || stack_depth >= STORE_SIZE) begin
                err_flag = 1;
                return;
            end
            stack_mem[stack_depth] = v;
            stack_depth++;
        endfunction

        function void execute(logic [3:0] m, longint v);
            longint lhs;
            longint rhs;
            longint t;
            case (m)
                OP_NUM: push_value(v);
                OP_POP, OP_INV, OP_DUP:
                begin
                    if (stack_depth == 0)
                        err_flag = 1;
                    else
                    begin
                        t = stack_mem[stack_depth - 1];
                        if (m == OP_POP)
                            stack_depth--;
                        else if (m == OP_INV)
                            stack_mem[stack_depth - 1] = -t;
                        else
                            push_value(t);
                    end
                end
                OP_SWP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                begin
                    if (stack_depth < 2)
                        err_flag = 1;
                    else
                    begin
                        rhs = stack_mem[stack_depth - 1];
                        lhs = stack_mem[stack_depth - 2];
                        if (m == OP_SWP)
                        begin
                            stack_mem[stack_depth - 1] = lhs;
                            stack_mem[stack_depth - 2] = rhs;
                        end
                        else if ((m == OP_DIV || m == OP_MOD) && rhs == 0)
                            err_flag = 1;
                        else
                        begin
                            case (m)
                                OP_ADD: t = lhs + rhs;
                                OP_SUB: t = lhs - rhs;
                                OP_MUL: t = lhs * rhs;
                                OP_DIV: t = lhs / rhs;
                                default: t = lhs % rhs;
                            endcase
                            stack_depth -= 2;
                            push_value(t);
                        end
                    end
                end
                default: err_flag = 1;
            endcase
            if (stack_depth == 0 || stack_depth >= depth_limit)
                err_flag = 1;
        endfunction

        function void note_instruction(logic [3:0] m, logic signed [30:0] opnd);
            calc_result_t r;
            longint v;
            v = opnd;
            r.final_ok = 0;
            if (m == OP_START)
            begin
                stack_depth = 0;
                err_flag = 0;
                push_value(v);
            end
            else if (m == OP_FINISH)
                r.final_ok = !err_flag && stack_depth == 1;
            else if (!err_flag)
                execute(m, v);
            r.error = err_flag;
            r.top_value = stack_depth ? stack_mem[stack_depth - 1][30:0] : '0;
            r.depth = stack_depth[10:0];
            expected_q = {expected_q, r};
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_result(calc_result_t got);
            calc_result_t want;
            if (expected_q.size() == 0)
            begin
                report("result word with no instruction pending");
                return;
            end
            want = expected_q.pop_front();
            if (got.error !== want.error)
                report($sformatf("error got %b want %b", got.error, want.error));
            if (got.top_value !== want.top_value)
                report($sformatf("top_value got %0d want %0d", got.top_value, want.top_value));
            if (got.depth !== want.depth)
                report($sformatf("depth got %0d want %0d", got.depth, want.depth));
            if (got.final_ok !== want.final_ok)
                report($sformatf("final_ok got %b want %b", got.final_ok, want.final_ok));
        endtask
    endclass

    logic               clk = 0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [3:0]         mode;
    logic signed [30:0] operand;
    logic               out_valid;
    logic               out_stall;
    logic               error;
    logic signed [30:0] top_value;
    logic [10:0]        depth;
    logic               final_ok;
    logic               cfg_write;
    logic [0:0]         cfg_index;
    logic [29:0]        cfg_data;

    calc_scoreboard sb = new();
    int  cycles = 0;
    bit  calm = 0;
    int  stall_left = 0;

    bounded_stack_calculator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .operand(operand),
        .out_valid(out_valid), .out_stall(out_stall),
        .error(error), .top_value(top_value), .depth(depth), .final_ok(final_ok),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            out_stall <= !calm && ($urandom_range(0, 2) == 0);
            stall_left <= gap_length();
        end
    end

    always @(posedge clk)
    begin
        calc_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.error = error;
            got.top_value = top_value;
            got.depth = depth;
            got.final_ok = final_ok;
            sb.check_result(got);
        end
    end

    task send_word(logic [3:0] m, logic signed [30:0] opnd);
        int idle;
        idle = gap_length();
        if (idle > 0)
        begin
            in_valid <= 0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1;
        mode <= m;
        operand <= opnd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_instruction(m, opnd);
    endtask

    task wait_idle();
        in_valid <= 0;
        while (sb.expected_q.size() > 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    task write_limit(reg_idx_t idx, logic [29:0] value);
        wait_idle();
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 0;
        sb.set_limit(idx, value);
    endtask

    function automatic logic signed [30:0] pick_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 31'(int'($urandom_range(0, 40)) - 20);
        if (r < 75)
            return 31'(int'($urandom_range(0, 2000)) - 1000);
        if (r < 80)
            return $urandom_range(0, 1) ? 31'(OPND_MAX) : 31'(-OPND_MAX);
        if (r < 84)
            return $urandom_range(0, 1) ? 31'sh3FFFFFFF : -31'sh40000000;
        return 31'(int'($urandom_range(0, 2 * OPND_MAX)) - OPND_MAX);
    endfunction

    task run_program(int len);
        int r;
        logic [3:0] m;
        send_word(OP_START, pick_operand());
        repeat (len)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                m = OP_NUM;
            else if (r < 96)
                m = 4'($urandom_range(OP_POP, OP_MOD));
            else if (r < 98)
                m = OP_FINISH;
            else
                m = 4'($urandom_range(OP_FINISH + 1, 15));
            send_word(m, pick_operand());
        end
        send_word(OP_FINISH, pick_operand());
    endtask

    task directed_words();
        send_word(OP_START, 31'(OPND_MAX));
        send_word(OP_FINISH, 0);
        send_word(OP_NUM, 31'(-OPND_MAX));
        send_word(OP_ADD, 0);
        send_word(OP_NUM, 0);
        send_word(OP_FINISH, 0);
        send_word(OP_START, -7);
        send_word(OP_NUM, 2);
        send_word(OP_MOD, 0);
        send_word(OP_INV, 0);
        send_word(OP_DUP, 0);
        send_word(OP_SWP, 0);
        send_word(OP_DIV, 0);
        send_word(OP_NUM, 0);
        send_word(OP_DIV, 0);
        send_word(OP_NUM, 5);
        send_word(OP_START, 100000);
        send_word(OP_DUP, 0);
        send_word(OP_MUL, 0);
        send_word(OP_START, 31'sh3FFFFFFF);
        send_word(OP_START, 1);
        send_word(OP_POP, 0);
        send_word(OP_START, 3);
        send_word(OP_SUB, 0);
        send_word(OP_START, 4);
        send_word(4'(OP_FINISH + 1), 0);
        send_word(4'hF, 0);
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        mode = OP_START;
        operand = 0;
        cfg_write = 0;
        cfg_index = REG_MAG_LIMIT;
        cfg_data = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        directed_words();
        calm = 1;
        repeat (6) run_program($urandom_range(4, 20));
        calm = 0;
        repeat (6) run_program($urandom_range(4, 20));

        write_limit(REG_DEPTH_LIMIT, 1024);
        repeat (6) run_program($urandom_range(10, 40));
        write_limit(REG_MAG_LIMIT, 1);
        write_limit(REG_DEPTH_LIMIT, 1);
        repeat (8) run_program($urandom_range(2, 8));
        write_limit(REG_MAG_LIMIT, 100);
        write_limit(REG_DEPTH_LIMIT, 4);
        repeat (12) run_program($urandom_range(3, 12));
        write_limit(REG_MAG_LIMIT, 30000);
        write_limit(REG_DEPTH_LIMIT, 8);
        repeat (12) run_program($urandom_range(5, 20));
        write_limit(REG_MAG_LIMIT, 1000000);
        write_limit(REG_DEPTH_LIMIT, 16);
        calm = 1;
        repeat (4) run_program($urandom_range(5, 20));
        calm = 0;
        repeat (8) run_program($urandom_range(5, 20));
        write_limit(REG_MAG_LIMIT, 30'(OPND_MAX));
        write_limit(REG_DEPTH_LIMIT, 1000);
        repeat (5) run_program($urandom_range(5, 25));

        wait_idle();
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
